// ----- rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int DEF_MAX_PAGES = 4096;
	localparam int DEF_TOP_RANK  = 16;

	localparam int CFG_W   = 13;
	localparam int OP_W    = 3;
	localparam int RANK_W  = 5;
	localparam int PAGE_W  = 12;
	localparam int STAT_W  = 2;
	localparam int ANS_W   = 13;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 3'd0,
		OP_ALLOC = 3'd1,
		OP_FREE  = 3'd2,
		OP_QRANK = 3'd3,
		OP_QCNT  = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_INVAL   = 2'd1,
		STAT_NOSPACE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_CALC,
		ST_MARK,
		ST_PUSH_A,
		ST_PUSH_B,
		ST_SRCH,
		ST_UNL_RD,
		ST_UNL_A,
		ST_UNL_B,
		ST_SPLIT,
		ST_FREE_CHK,
		ST_MRG_RD,
		ST_MRG_CHK,
		ST_QR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [RANK_W-1:0] req_rank;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PAGE_W-1:0] block_page;
		logic [ANS_W-1:0]  answer_value;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/bpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Synchronous memory, one write and one read port, two write-enabled fields.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int DW    = 6,
	parameter int LW    = 1,
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we_hi,
	input  wire logic          we_lo,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we_hi) begin
			mem[waddr][DW-1:LW] <= wdata[DW-1:LW];
		end
		if (we_lo) begin
			mem[waddr][LW-1:0] <= wdata[LW-1:0];
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/bpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: free lists, counts and page memory updates.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; #(
	parameter int MAX_PAGES = DEF_MAX_PAGES,
	parameter int TOP_RANK  = DEF_TOP_RANK,
	parameter int AW        = 12,
	parameter int PW        = 13,
	parameter int RW        = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire req_t              req,
	input  wire logic [CFG_W-1:0]  cfg_pages,
	output logic                   busy,
	output logic                   done,
	output rsp_t                   rsp,
	output logic                   rk_we,
	output logic [AW-1:0]          rk_waddr,
	output logic [RW:0]            rk_wdata,
	output logic [AW-1:0]          rk_raddr,
	input  wire logic [RW:0]       rk_rdata,
	output logic                   lk_we_hi,
	output logic                   lk_we_lo,
	output logic [AW-1:0]          lk_waddr,
	output logic [2*PW-1:0]        lk_wdata,
	output logic [AW-1:0]          lk_raddr,
	input  wire logic [2*PW-1:0]   lk_rdata
);

	localparam int HW = (TOP_RANK > 1) ? $clog2(TOP_RANK) : 1;
	localparam int XW = ((AW > TOP_RANK) ? AW : TOP_RANK) + 2;
	localparam logic [PW-1:0] EMPTY = PW'(MAX_PAGES);
	localparam logic [RW-1:0] RTOP  = RW'(TOP_RANK);

	function automatic logic [XW-1:0] blen(input logic [RW-1:0] r);
		logic [RW-1:0] s;
		s = r - RW'(1);
		blen = XW'(1) << s;
	endfunction

	function automatic logic [HW-1:0] hidx(input logic [RW-1:0] r);
		logic [RW-1:0] t;
		t = r - RW'(1);
		hidx = t[HW-1:0];
	endfunction

	state_t state_q, state_d;

	opcode_t          op_q;
	logic [RW-1:0]    rank_q, r_q, mr_q;
	logic [PAGE_W-1:0] pg_q;
	logic [PW-1:0]    size_q;
	logic             ready_q;
	logic [XW-1:0]    b_q, m_q, u_q, cnt_q;
	logic             mbit_q, final_q;
	logic [PW-1:0]    h_q, pv_q, nx_q;
	logic [STAT_W-1:0] st_q;
	logic [PAGE_W-1:0] blk_q;
	logic [ANS_W-1:0] ans_q;
	logic [PW-1:0]    head_q [TOP_RANK];
	logic [PW-1:0]    fc_q [TOP_RANK];

	logic             rank_ok, pg_ok, n_ok;
	logic [RW-1:0]    req_rank_rw;
	logic [XW-1:0]    bud_x, rem_x;
	logic [PW-1:0]    head_cur, head_push, lk_prev, lk_next;
	logic [RW-1:0]    rk_rank, br;
	logic             rk_mark, mark_last, free_bad, mrg_stop, mrg_match;
	logic             push_fin, init_end;
	int               lo_i, hi_i, b_i;

	assign req_rank_rw = RW'(req.req_rank);
	assign rank_ok   = (req.req_rank != '0) && (req.req_rank <= RANK_W'(TOP_RANK));
	assign pg_ok     = ready_q && (XW'(req.page_index) < XW'(size_q));
	assign n_ok      = (cfg_pages != '0) && (32'(cfg_pages) <= 32'(MAX_PAGES));
	assign bud_x     = b_q ^ blen(r_q);
	assign rem_x     = XW'(size_q) - m_q;
	assign head_cur  = head_q[hidx(r_q)];
	assign head_push = head_q[hidx(mr_q)];
	assign lk_prev   = lk_rdata[2*PW-1:PW];
	assign lk_next   = lk_rdata[PW-1:0];
	assign rk_rank   = rk_rdata[RW:1];
	assign rk_mark   = rk_rdata[0];
	assign mark_last = (cnt_q == blen(mr_q) - XW'(1));
	assign free_bad  = (rk_rank == '0) || (rk_rank > RTOP) ||
		((XW'(pg_q) & (blen(rk_rank) - XW'(1))) != '0) || !rk_mark;
	assign mrg_stop  = (r_q >= RTOP) || (bud_x >= XW'(size_q));
	assign mrg_match = (rk_rank == r_q) && !rk_mark;
	assign push_fin  = ((state_q == ST_PUSH_A) && (head_push == EMPTY)) ||
		(state_q == ST_PUSH_B);
	assign init_end  = (m_q + blen(mr_q)) >= XW'(size_q);

	// largest aligned block at the init position
	always_comb begin
		lo_i = XW;
		for (int i = XW - 1; i >= 0; i--) begin
			if (m_q[i]) begin
				lo_i = i;
			end
		end
		hi_i = 0;
		for (int i = 0; i < XW; i++) begin
			if (rem_x[i]) begin
				hi_i = i;
			end
		end
		b_i = TOP_RANK;
		if (lo_i + 1 < b_i) begin
			b_i = lo_i + 1;
		end
		if (hi_i + 1 < b_i) begin
			b_i = hi_i + 1;
		end
		br = RW'(b_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rk_we    = 1'b0;
		rk_waddr = AW'(m_q + cnt_q);
		rk_wdata = {mr_q, mbit_q && (cnt_q == '0)};
		rk_raddr = AW'(bud_x);
		lk_we_hi = 1'b0;
		lk_we_lo = 1'b0;
		lk_waddr = AW'(m_q);
		lk_wdata = {EMPTY, head_push};
		lk_raddr = AW'(u_q);
		case (state_q)
			ST_IDLE: begin
				rk_raddr = AW'(req.page_index);
				if (start) begin
					case (req.opcode)
						OP_INIT:  state_d = n_ok ? ST_INIT_CALC : ST_DONE;
						OP_ALLOC: state_d = (rank_ok && ready_q) ? ST_SRCH : ST_DONE;
						OP_FREE:  state_d = pg_ok ? ST_FREE_CHK : ST_DONE;
						OP_QRANK: state_d = pg_ok ? ST_QR : ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_INIT_CALC: state_d = ST_MARK;
			ST_MARK: begin
				rk_we = 1'b1;
				if (mark_last) begin
					state_d = (op_q == OP_ALLOC && final_q) ? ST_DONE : ST_PUSH_A;
				end
			end
			ST_PUSH_A: begin
				lk_we_hi = 1'b1;
				lk_we_lo = 1'b1;
				if (head_push != EMPTY) begin
					state_d = ST_PUSH_B;
				end
			end
			ST_PUSH_B: begin
				lk_we_hi = 1'b1;
				lk_waddr = AW'(h_q);
				lk_wdata = {PW'(m_q), head_push};
			end
			ST_SRCH: begin
				if (head_cur != EMPTY) begin
					state_d = ST_UNL_RD;
				end else if (r_q == RTOP) begin
					state_d = ST_DONE;
				end
			end
			ST_UNL_RD: state_d = ST_UNL_A;
			ST_UNL_A: begin
				lk_waddr = AW'(lk_prev);
				lk_wdata = {lk_prev, lk_next};
				lk_we_lo = (lk_prev != EMPTY);
				if (lk_next != EMPTY) begin
					state_d = ST_UNL_B;
				end else begin
					state_d = (op_q == OP_ALLOC) ? ST_SPLIT : ST_MRG_RD;
				end
			end
			ST_UNL_B: begin
				lk_we_hi = 1'b1;
				lk_waddr = AW'(nx_q);
				lk_wdata = {pv_q, nx_q};
				state_d  = (op_q == OP_ALLOC) ? ST_SPLIT : ST_MRG_RD;
			end
			ST_SPLIT:    state_d = ST_MARK;
			ST_FREE_CHK: state_d = free_bad ? ST_DONE : ST_MRG_RD;
			ST_MRG_RD:   state_d = mrg_stop ? ST_MARK : ST_MRG_CHK;
			ST_MRG_CHK:  state_d = mrg_match ? ST_UNL_RD : ST_MARK;
			ST_QR:       state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
		if (push_fin) begin
			case (op_q)
				OP_INIT:  state_d = init_end ? ST_DONE : ST_INIT_CALC;
				OP_ALLOC: state_d = ST_SPLIT;
				default:  state_d = ST_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			size_q  <= '0;
			for (int i = 0; i < TOP_RANK; i++) begin
				head_q[i] <= EMPTY;
				fc_q[i]   <= '0;
			end
		end else begin
			if (state_q == ST_IDLE && start && req.opcode == OP_INIT && n_ok) begin
				ready_q <= 1'b1;
				size_q  <= PW'(cfg_pages);
				for (int i = 0; i < TOP_RANK; i++) begin
					head_q[i] <= EMPTY;
					fc_q[i]   <= '0;
				end
			end
			if (state_q == ST_PUSH_A) begin
				head_q[hidx(mr_q)] <= PW'(m_q);
				fc_q[hidx(mr_q)]   <= fc_q[hidx(mr_q)] + PW'(1);
			end
			if (state_q == ST_UNL_A) begin
				if (lk_prev == EMPTY) begin
					head_q[hidx(r_q)] <= lk_next;
				end
				fc_q[hidx(r_q)] <= fc_q[hidx(r_q)] - PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q   <= opcode_t'(req.opcode);
					rank_q <= req_rank_rw;
					pg_q   <= req.page_index;
					r_q    <= req_rank_rw;
					m_q    <= '0;
					st_q   <= STAT_OK;
					blk_q  <= '0;
					ans_q  <= '0;
					case (req.opcode)
						OP_INIT: begin
							if (!n_ok) begin
								st_q <= STAT_INVAL;
							end
						end
						OP_ALLOC: begin
							if (!rank_ok) begin
								st_q <= STAT_INVAL;
							end else if (!ready_q) begin
								st_q <= STAT_NOSPACE;
							end
						end
						OP_FREE, OP_QRANK: begin
							if (!pg_ok) begin
								st_q <= STAT_INVAL;
							end
						end
						OP_QCNT: begin
							if (rank_ok) begin
								ans_q <= ANS_W'(fc_q[hidx(req_rank_rw)]);
							end else begin
								st_q <= STAT_INVAL;
							end
						end
						default: st_q <= STAT_INVAL;
					endcase
				end
			end
			ST_INIT_CALC: begin
				mr_q   <= br;
				cnt_q  <= '0;
				mbit_q <= 1'b0;
			end
			ST_MARK: begin
				cnt_q <= cnt_q + XW'(1);
				if (mark_last && op_q == OP_ALLOC && final_q) begin
					blk_q <= PAGE_W'(m_q);
				end
			end
			ST_PUSH_A: h_q <= head_push;
			ST_SRCH: begin
				if (head_cur != EMPTY) begin
					u_q <= XW'(head_cur);
					b_q <= XW'(head_cur);
				end else if (r_q == RTOP) begin
					st_q <= STAT_NOSPACE;
				end else begin
					r_q <= r_q + RW'(1);
				end
			end
			ST_UNL_A: begin
				pv_q <= lk_prev;
				nx_q <= lk_next;
			end
			ST_SPLIT: begin
				cnt_q <= '0;
				if (r_q > rank_q) begin
					r_q     <= r_q - RW'(1);
					mr_q    <= r_q - RW'(1);
					m_q     <= b_q + blen(r_q - RW'(1));
					mbit_q  <= 1'b0;
					final_q <= 1'b0;
				end else begin
					m_q     <= b_q;
					mr_q    <= rank_q;
					mbit_q  <= 1'b1;
					final_q <= 1'b1;
				end
			end
			ST_FREE_CHK: begin
				b_q <= XW'(pg_q);
				if (free_bad) begin
					st_q <= STAT_INVAL;
				end else begin
					r_q <= rk_rank;
				end
			end
			ST_MRG_RD: begin
				u_q    <= bud_x;
				m_q    <= b_q;
				mr_q   <= r_q;
				mbit_q <= 1'b0;
				cnt_q  <= '0;
			end
			ST_QR: ans_q <= ANS_W'(rk_rank);
			default: begin
			end
		endcase
		if (push_fin && op_q == OP_INIT) begin
			m_q <= m_q + blen(mr_q);
		end
		if (op_q == OP_FREE && ((state_q == ST_UNL_A && lk_next == EMPTY) ||
			state_q == ST_UNL_B)) begin
			if (u_q < b_q) begin
				b_q <= u_q;
			end
			r_q <= r_q + RW'(1);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign rsp  = '{status: st_q, block_page: blk_q, answer_value: ans_q};

endmodule
`default_nettype wire

// ----- rtl/buddy_page_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a pool of pages, state held in two page memories.
//
//   channel  signals                       transaction
//   request  start, busy, req              start high while busy low
//   result   done, rsp                     one cycle strobe on done
//   config   cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// query count and bad arguments answer at once; query rank first reads the page memory.
// alloc: searches ranks upward, unlinks the block found, per split marks the pages
//   of the split-off half and pushes it, then marks the pages of the allocated block.
// free: checks the page, reads and unlinks the buddy per merge step, then marks and pushes the block.
// init: marks every pool page and pushes each block in turn; page write port bound.
// reset clears lists, counts and ready flag; page memories need no clearing.
// busy stays high until the done strobe; the result side never stalls.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int MAX_PAGES = DEF_MAX_PAGES,
	parameter int TOP_RANK  = DEF_TOP_RANK
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	output logic                  done,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int RW = $clog2(TOP_RANK + 1);

	logic [CFG_W-1:0] cfg_q;
	logic             rk_we;
	logic [AW-1:0]    rk_waddr, rk_raddr;
	logic [RW:0]      rk_wdata, rk_rdata;
	logic             lk_we_hi, lk_we_lo;
	logic [AW-1:0]    lk_waddr, lk_raddr;
	logic [2*PW-1:0]  lk_wdata, lk_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	bpa_ctrl #(
		.MAX_PAGES(MAX_PAGES),
		.TOP_RANK (TOP_RANK),
		.AW       (AW),
		.PW       (PW),
		.RW       (RW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cfg_pages(cfg_q),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp),
		.rk_we    (rk_we),
		.rk_waddr (rk_waddr),
		.rk_wdata (rk_wdata),
		.rk_raddr (rk_raddr),
		.rk_rdata (rk_rdata),
		.lk_we_hi (lk_we_hi),
		.lk_we_lo (lk_we_lo),
		.lk_waddr (lk_waddr),
		.lk_wdata (lk_wdata),
		.lk_raddr (lk_raddr),
		.lk_rdata (lk_rdata)
	);

	// page rank and allocated mark
	bpa_ram #(
		.DW   (RW + 1),
		.LW   (1),
		.DEPTH(MAX_PAGES),
		.AW   (AW)
	) u_rank_ram (
		.clk  (clk),
		.we_hi(rk_we),
		.we_lo(rk_we),
		.waddr(rk_waddr),
		.wdata(rk_wdata),
		.raddr(rk_raddr),
		.rdata(rk_rdata)
	);

	// free list links, prev in upper field and next in lower field
	bpa_ram #(
		.DW   (2 * PW),
		.LW   (PW),
		.DEPTH(MAX_PAGES),
		.AW   (AW)
	) u_link_ram (
		.clk  (clk),
		.we_hi(lk_we_hi),
		.we_lo(lk_we_lo),
		.waddr(lk_waddr),
		.wdata(lk_wdata),
		.raddr(lk_raddr),
		.rdata(lk_rdata)
	);

endmodule
`default_nettype wire

// ----- tb/tb_buddy_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator
// Drives pool size writes and init, alloc, free, query and invalid commands into the
// buddy page allocator with random gaps, predicts every result with an independent buddy
// model and compares each strobed result field by field in order.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;
	import bpa_pkg::*;

	localparam int NPAGE = DEF_MAX_PAGES;
	localparam int NRANK = DEF_TOP_RANK;
	localparam int NONE = NPAGE;
	localparam int WATCH_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	buddy_page_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// allocator mirror
	int pg_rank [NPAGE];
	int prv [NPAGE];
	int nxt [NPAGE];
	bit used [NPAGE];
	int head [NRANK];
	int cnt [NRANK];
	bit ready;
	int pool;
	int pool_cfg;

	rsp_t expected_rsp [$];
	int errors = 0;
	int idle_cycles = 0;
	int gap_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int blen(int r);
		return 1 << (r - 1);
	endfunction

	function automatic void fill_span_rank(int b, int r);
		for (int i = 0; i < blen(r) && b + i < NPAGE; i++) pg_rank[b + i] = r;
	endfunction

	function automatic void unlink_blk(int b, int r);
		int p;
		int n;
		p = prv[b];
		n = nxt[b];
		if (p < NPAGE) nxt[p] = n;
		else head[r - 1] = n;
		if (n < NPAGE) prv[n] = p;
		prv[b] = NONE;
		nxt[b] = NONE;
		cnt[r - 1]--;
	endfunction

	function automatic void push_blk(int b, int r);
		int h;
		h = head[r - 1];
		prv[b] = NONE;
		nxt[b] = h;
		if (h < NPAGE) prv[h] = b;
		head[r - 1] = b;
		cnt[r - 1]++;
	endfunction

	function automatic void clear_lists();
		for (int r = 0; r < NRANK; r++) begin
			head[r] = NONE;
			cnt[r] = 0;
		end
	endfunction

	function automatic rsp_t predict_allocator(req_t q);
		rsp_t o;
		int op;
		int rk;
		int pg;
		int k;
		int b;
		int r;
		int bud;
		int pos;
		int sz;
		int n;
		op = q.opcode;
		rk = q.req_rank;
		pg = q.page_index;
		o = '0;
		o.status = STAT_OK;
		case (op)
			OP_INIT: begin
				n = pool_cfg;
				if (n == 0 || n > NPAGE) o.status = STAT_INVAL;
				else begin
					ready = 1;
					pool = n;
					clear_lists();
					pos = 0;
					while (pos < n) begin
						sz = 1;
						r = 1;
						while (sz * 2 <= n - pos && r < NRANK && (pos % (sz * 2)) == 0) begin
							sz *= 2;
							r++;
						end
						fill_span_rank(pos, r);
						used[pos] = 0;
						push_blk(pos, r);
						pos += sz;
					end
				end
			end
			OP_ALLOC: begin
				if (rk < 1 || rk > NRANK) o.status = STAT_INVAL;
				else if (!ready) o.status = STAT_NOSPACE;
				else begin
					k = rk;
					while (k <= NRANK && head[k - 1] >= NPAGE) k++;
					if (k > NRANK) o.status = STAT_NOSPACE;
					else begin
						b = head[k - 1];
						unlink_blk(b, k);
						while (k > rk) begin
							k--;
							bud = b + blen(k);
							if (bud < NPAGE) begin
								fill_span_rank(bud, k);
								used[bud] = 0;
								push_blk(bud, k);
							end
						end
						fill_span_rank(b, rk);
						used[b] = 1;
						o.block_page = b[PAGE_W-1:0];
					end
				end
			end
			OP_FREE: begin
				if (!ready || pg >= pool) o.status = STAT_INVAL;
				else begin
					b = pg;
					r = pg_rank[b];
					if (r < 1 || r > NRANK || (b % blen(r)) != 0 || !used[b])
						o.status = STAT_INVAL;
					else begin
						used[b] = 0;
						while (r < NRANK) begin
							bud = b ^ blen(r);
							if (bud >= pool || pg_rank[bud] != r || used[bud]) break;
							unlink_blk(bud, r);
							if (bud < b) b = bud;
							r++;
						end
						fill_span_rank(b, r);
						push_blk(b, r);
					end
				end
			end
			OP_QRANK: begin
				if (!ready || pg >= pool) o.status = STAT_INVAL;
				else o.answer_value = ANS_W'(pg_rank[pg]);
			end
			OP_QCNT: begin
				if (rk < 1 || rk > NRANK) o.status = STAT_INVAL;
				else o.answer_value = ANS_W'(cnt[rk - 1]);
			end
			default: o.status = STAT_INVAL;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) report_mismatch("unexpected result", 1, 0);
			else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) report_mismatch("status", rsp.status, e.status);
				if (rsp.block_page !== e.block_page)
					report_mismatch("block_page", rsp.block_page, e.block_page);
				if (rsp.answer_value !== e.answer_value)
					report_mismatch("answer_value", rsp.answer_value, e.answer_value);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("tb_buddy_page_allocator failed");
			$finish;
		end
	end

	task automatic send_cmd(opcode_t op, int rk, int pg);
		@(negedge clk);
		if (gap_left == 0) begin
			gap_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		gap_left--;
		start <= 1'b1;
		req.opcode <= op;
		req.req_rank <= rk[RANK_W-1:0];
		req.page_index <= pg[PAGE_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsp.push_back(predict_allocator({op, rk[RANK_W-1:0], pg[PAGE_W-1:0]}));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain();
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_pool_size(int n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pool_cfg = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_before_init();
		send_cmd(OP_ALLOC, 1, 0);
		send_cmd(OP_ALLOC, 0, 0);
		send_cmd(OP_FREE, 0, 0);
		send_cmd(OP_QRANK, 0, 0);
		send_cmd(OP_QCNT, 16, 0);
		send_cmd(OP_QCNT, 31, 0);
		send_cmd(opcode_t'(3'd5), 3, 7);
		send_cmd(opcode_t'(3'd7), 31, 4095);
	endtask

	task automatic test_bad_pool();
		write_pool_size(0);
		send_cmd(OP_INIT, 0, 0);
		write_pool_size(8191);
		send_cmd(OP_INIT, 0, 0);
		write_pool_size(4097);
		send_cmd(OP_INIT, 0, 0);
	endtask

	task automatic test_directed_full();
		write_pool_size(4096);
		send_cmd(OP_INIT, 0, 0);
		send_cmd(OP_QCNT, 13, 0);
		send_cmd(OP_ALLOC, 16, 0);
		send_cmd(OP_ALLOC, 1, 0);
		send_cmd(OP_QRANK, 0, 4095);
		send_cmd(OP_FREE, 0, 0);
		send_cmd(OP_FREE, 0, 0);
		send_cmd(OP_FREE, 0, 4095);
		send_cmd(OP_ALLOC, 17, 0);
		send_cmd(OP_QCNT, 0, 0);
		send_cmd(OP_ALLOC, 1, 0);
		send_cmd(OP_FREE, 0, 0);
		send_cmd(OP_QCNT, 16, 0);
	endtask

	task automatic random_phase(int pages, int items);
		int live [$];
		int i;
		int k;
		write_pool_size(pages);
		send_cmd(OP_INIT, 0, 0);
		for (i = 0; i < items; i++) begin
			k = $urandom_range(0, 99);
			if (k < 40) send_cmd(OP_ALLOC, $urandom_range(1, 5), 0);
			else if (k < 43) send_cmd(OP_ALLOC, $urandom_range(6, 16), 0);
			else if (k < 70 && live.size() != 0) begin
				int j;
				j = $urandom_range(0, live.size() - 1);
				send_cmd(OP_FREE, 0, live[j]);
				live.delete(j);
			end else if (k < 78) send_cmd(OP_FREE, 0, $urandom_range(0, 4095));
			else if (k < 86) send_cmd(OP_QRANK, 0, $urandom_range(0, 4095));
			else if (k < 94) send_cmd(OP_QCNT, $urandom_range(0, 31), 0);
			else if (k < 96) send_cmd(opcode_t'($urandom_range(5, 7)),
				$urandom_range(0, 31), $urandom_range(0, 4095));
			else send_cmd(OP_INIT, 0, 0);
			if (req.opcode == OP_INIT) live.delete();
			if (req.opcode == OP_ALLOC && expected_rsp.size() != 0
				&& expected_rsp[$].status == STAT_OK)
				live.push_back(expected_rsp[$].block_page);
		end
	endtask

	initial begin
		gap_left = 0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < NPAGE; i++) begin
			pg_rank[i] = 0;
			prv[i] = 0;
			nxt[i] = 0;
			used[i] = 0;
		end
		clear_lists();
		ready = 0;
		pool = 0;
		pool_cfg = 4096;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_before_init();
		test_bad_pool();
		test_directed_full();
		random_phase(1, 100);
		random_phase(37, 400);
		random_phase(100, 500);
		random_phase(255, 500);
		random_phase(4095, 300);
		random_phase(4096, 200);
		drain();
		if (errors == 0) $display("tb_buddy_page_allocator passed");
		else $display("tb_buddy_page_allocator failed");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator.sv
tb/tb_buddy_page_allocator.sv
